FILE: hdl/assert_macros.svh
// Assertion macros for the RTL of the camera projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/gpcp_pkg.sv
// Types and constants of the ground point camera projection block.
`default_nettype none

package gpcp_pkg;

  localparam int unsigned CoordBits = 20;
  localparam int unsigned InDataW   = ((2 * CoordBits + 7) / 8) * 8;
  localparam int unsigned OutDataW  = ((2 * CoordBits + 7) / 8) * 8;
  localparam int unsigned OutUserW  = 2;

  localparam int unsigned CfgW    = 60;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned RotW   = 18;
  localparam int unsigned TrW    = 24;
  localparam int unsigned ParW   = 24;
  localparam int unsigned ScrW   = 12;
  localparam int unsigned QBits  = 20;
  localparam int unsigned ProdW  = RotW + CoordBits;
  localparam int unsigned CamW   = ((ProdW > TrW + 16) ? ProdW : TrW + 16) + 2;
  localparam int unsigned MagW   = CamW;
  localparam int unsigned RemW   = MagW + 4;
  localparam int unsigned QuoW   = 24;

  localparam int unsigned X1W    = QuoW + 1;
  localparam int unsigned SqW    = 2 * X1W;
  localparam int unsigned R2W    = 29;
  localparam int unsigned R2SqW  = 2 * R2W;
  localparam int unsigned R4W    = R2SqW - QBits;
  localparam int unsigned K1R2W  = ParW + R2W + 1;
  localparam int unsigned K2R4W  = ParW + R4W + 1;
  localparam int unsigned DsumW  = K2R4W + 1;
  localparam int unsigned ScW    = DsumW - QBits + 1;
  localparam int unsigned ScQW   = 32;
  localparam int unsigned PxsW   = X1W + ScQW;
  localparam int unsigned X2W    = PxsW - QBits;
  localparam int unsigned FxxW   = ParW + X2W;
  localparam int unsigned UnW    = FxxW - QBits + 1;
  localparam int unsigned UwW    = UnW + ScrW + 1;
  localparam int unsigned PuW    = UwW - 16;

  localparam int unsigned PreStages  = 4;
  localparam int unsigned DivStages  = QuoW;
  localparam int unsigned PostStages = 13;
  localparam int unsigned PipeStages = PreStages + DivStages + PostStages;

  localparam logic [QuoW-1:0]    QSat    = '1;
  localparam logic signed [63:0] OneQ20  = 64'sd1 <<< QBits;
  localparam logic signed [63:0] ScMax   = 64'sd2147483647;
  localparam logic signed [63:0] ScMin   = -ScMax;
  localparam logic signed [63:0] OutMax  = (64'sd1 <<< (CoordBits - 1)) - 64'sd1;
  localparam logic signed [63:0] OutMin  = -OutMax - 64'sd1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCamRowX,
    CfgCamRowY,
    CfgCamRowZ,
    CfgFocal,
    CfgCenter,
    CfgDistCoef,
    CfgScreen,
    CfgDistEn
  } cfg_reg_e;

  // Per-word flags that ride along the divider stages.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
    logic dz;
  } div_side_t;

  typedef struct packed {
    logic dz;
    logic clip;
  } flags_t;

endpackage

`default_nettype wire

FILE: hdl/ground_point_camera_projection_top.sv
// Top level of the ground point camera projection pipeline.
//
// Usage: configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i while the block is idle; a write takes effect at the next edge.
// Ground points enter on the s_axis channel, one word per point, and each one
// gives exactly one word on the m_axis channel with pixel u, v and two flags.
// A new point can be taken in every cycle while the pipeline is not frozen,
// so the sustained rate is one word per clock. A result word passes 42
// registers: four stages form and condition the camera coordinates, 24 stages
// run the divider at one quotient bit each, 13 stages apply distortion and
// intrinsics, and one output register holds the word for the receiver. The
// accepting edge loads the first of them, and the word is presented on
// m_axis once the output register holds it.
// When the receiver stalls, the output word holds and the pipeline keeps
// moving as long as its last stage is empty; once that stage is full the
// whole pipeline freezes and s_axis_tready drops, so nothing is lost.
// Reset empties the pipeline and loads the register defaults: all zero, with
// distortion enabled.
`default_nettype none
`include "assert_macros.svh"

module ground_point_camera_projection_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // s_axis_tdata: world_x, world_y
  input  wire logic [gpcp_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // m_axis_tdata: pixel_u, pixel_v
  output logic      [gpcp_pkg::OutDataW-1:0]  m_axis_tdata,
  // m_axis_tuser: depth_zero, clipped
  output logic      [gpcp_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           cfg_we_i,
  input  wire logic [gpcp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [gpcp_pkg::CfgW-1:0]      cfg_data_i
);
  import gpcp_pkg::*;

  // Configuration registers
  logic [59:0] cam_row_x_q, cam_row_y_q, cam_row_z_q;
  logic [47:0] focal_q, center_q, dist_q;
  logic [23:0] screen_q;
  logic        dist_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_row_x_q <= '0;
      cam_row_y_q <= '0;
      cam_row_z_q <= '0;
      focal_q     <= '0;
      center_q    <= '0;
      dist_q      <= '0;
      screen_q    <= '0;
      dist_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgCamRowX:  cam_row_x_q <= cfg_data_i[59:0];
        CfgCamRowY:  cam_row_y_q <= cfg_data_i[59:0];
        CfgCamRowZ:  cam_row_z_q <= cfg_data_i[59:0];
        CfgFocal:    focal_q     <= cfg_data_i[47:0];
        CfgCenter:   center_q    <= cfg_data_i[47:0];
        CfgDistCoef: dist_q      <= cfg_data_i[47:0];
        CfgScreen:   screen_q    <= cfg_data_i[23:0];
        CfgDistEn:   dist_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic signed [RotW-1:0]      rxa, rxb, rya, ryb, rza, rzb;
  logic signed [TrW-1:0]       tx, ty, tz;
  logic signed [ParW-1:0]      fx, fy, cx, cy, k1, k2;
  logic        [ScrW-1:0]      scr_w, scr_h;
  logic signed [CoordBits-1:0] wx, wy;

  assign rxa   = cam_row_x_q[17:0];
  assign rxb   = cam_row_x_q[35:18];
  assign tx    = cam_row_x_q[59:36];
  assign rya   = cam_row_y_q[17:0];
  assign ryb   = cam_row_y_q[35:18];
  assign ty    = cam_row_y_q[59:36];
  assign rza   = cam_row_z_q[17:0];
  assign rzb   = cam_row_z_q[35:18];
  assign tz    = cam_row_z_q[59:36];
  assign fx    = focal_q[23:0];
  assign fy    = focal_q[47:24];
  assign cx    = center_q[23:0];
  assign cy    = center_q[47:24];
  assign k1    = dist_q[23:0];
  assign k2    = dist_q[47:24];
  assign scr_w = screen_q[11:0];
  assign scr_h = screen_q[23:12];
  assign wx    = s_axis_tdata[CoordBits-1:0];
  assign wy    = s_axis_tdata[2*CoordBits-1:CoordBits];

  // Flow control: the pipeline moves unless a full last stage meets a held
  // output word.
  logic [PipeStages-1:0] pipe_v_q;
  logic                  out_v_q;
  logic                  out_v_d;
  logic                  en;

  assign en            = !out_v_q || m_axis_tready || !pipe_v_q[PipeStages-1];
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign out_v_d       = (en && pipe_v_q[PipeStages-1]) || (out_v_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (en) begin
        pipe_v_q <= {pipe_v_q[PipeStages-2:0], s_axis_tvalid};
      end
      out_v_q <= out_v_d;
    end
  end

  // Stage 1: extrinsic products
  logic signed [ProdW-1:0] pxa_d, pxb_d, pya_d, pyb_d, pza_d, pzb_d;
  logic signed [ProdW-1:0] pxa_q, pxb_q, pya_q, pyb_q, pza_q, pzb_q;
  assign pxa_d = rxa * wx;
  assign pxb_d = rxb * wy;
  assign pya_d = rya * wx;
  assign pyb_d = ryb * wy;
  assign pza_d = rza * wx;
  assign pzb_d = rzb * wy;

  // Stage 2: camera coordinates in units of 2^-26 m
  logic signed [CamW-1:0] txs, tys, tzs;
  logic signed [CamW-1:0] xc_d, yc_d, zc_d, xc_q, yc_q, zc_q;
  assign txs  = $signed({tx, 16'b0});
  assign tys  = $signed({ty, 16'b0});
  assign tzs  = $signed({tz, 16'b0});
  assign xc_d = pxa_q + pxb_q + txs;
  assign yc_d = pya_q + pyb_q + tys;
  assign zc_d = pza_q + pzb_q + tzs;

  // Stage 3: magnitudes and quotient signs; x is mirrored.
  logic [MagW-1:0] mx_q, my_q, mz_q;
  logic            negx3_q, negy3_q, dz3_q;
  logic signed [CamW-1:0] nxc, nyc, nzc;
  assign nxc = -xc_q;
  assign nyc = -yc_q;
  assign nzc = -zc_q;

  // Stage 4: overflow check and divider operands
  logic [MagW-1:0] nx_q, ny_q, d_q;
  logic            sat_x, sat_y;
  div_side_t       side4_q;
  assign sat_x = (RemW'(mx_q) >= {mz_q, 4'b0000});
  assign sat_y = (RemW'(my_q) >= {mz_q, 4'b0000});

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxa_q <= pxa_d;
      pxb_q <= pxb_d;
      pya_q <= pya_d;
      pyb_q <= pyb_d;
      pza_q <= pza_d;
      pzb_q <= pzb_d;
      xc_q  <= xc_d;
      yc_q  <= yc_d;
      zc_q  <= zc_d;
      mx_q    <= xc_q[CamW-1] ? MagW'(nxc) : MagW'(xc_q);
      my_q    <= yc_q[CamW-1] ? MagW'(nyc) : MagW'(yc_q);
      mz_q    <= zc_q[CamW-1] ? MagW'(nzc) : MagW'(zc_q);
      negx3_q <= (!xc_q[CamW-1] && (xc_q != '0)) != zc_q[CamW-1];
      negy3_q <= yc_q[CamW-1] != zc_q[CamW-1];
      dz3_q   <= (zc_q == '0);
      nx_q          <= sat_x ? '0 : mx_q;
      ny_q          <= sat_y ? '0 : my_q;
      d_q           <= mz_q;
      side4_q.neg_x <= negx3_q;
      side4_q.neg_y <= negy3_q;
      side4_q.sat_x <= sat_x;
      side4_q.sat_y <= sat_y;
      side4_q.dz    <= dz3_q;
    end
  end

  // Divider stages
  logic [QuoW-1:0] quo_x, quo_y;
  div_side_t       side_q [DivStages];

  gpcp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nx_q),
    .den_i (d_q),
    .quo_o (quo_x)
  );

  gpcp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ny_q),
    .den_i (d_q),
    .quo_o (quo_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side4_q;
      for (int i = 1; i < DivStages; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Post-divide stages
  div_side_t             sd;
  logic [QuoW-1:0]       qx, qy;
  logic signed [X1W-1:0] qx_s, qy_s, x1_d, y1_d;
  assign sd   = side_q[DivStages-1];
  assign qx   = sd.sat_x ? QSat : quo_x;
  assign qy   = sd.sat_y ? QSat : quo_y;
  assign qx_s = $signed({1'b0, qx});
  assign qy_s = $signed({1'b0, qy});
  assign x1_d = sd.neg_x ? -qx_s : qx_s;
  assign y1_d = sd.neg_y ? -qy_s : qy_s;

  flags_t                flg_q [PostStages];
  logic signed [X1W-1:0] x1_q [9];
  logic signed [X1W-1:0] y1_q [9];

  logic signed [SqW-1:0]   sqx_d, sqy_d;
  logic        [SqW-1:0]   sqx_q, sqy_q, r2sum;
  logic        [R2W-1:0]   r2_q;
  logic        [R2SqW-1:0] r2sq_d, r2sq_q;
  logic signed [K1R2W-1:0] k1r2_d, k1r2_q, k1r2b_q, k1r2c_q;
  logic        [R4W-1:0]   r4_q;
  logic signed [K2R4W-1:0] k2r4_d, k2r4_q;
  logic signed [DsumW-1:0] dsum_d, dsum_q;
  logic signed [ScW-1:0]   sc_full;
  logic signed [ScQW-1:0]  sc_d, sc_q;
  logic                    sc_clip;
  logic signed [PxsW-1:0]  pxs_d, pys_d, pxs_q, pys_q;
  logic signed [X2W-1:0]   x2_d, y2_d, x2_q, y2_q;
  logic signed [FxxW-1:0]  fxx_d, fyy_d, fxx_q, fyy_q;
  logic signed [UnW-1:0]   un_d, vn_d, un_q, vn_q;
  logic signed [UwW-1:0]   uw_d, vh_d, uw_q, vh_q;

  assign sqx_d  = x1_q[0] * x1_q[0];
  assign sqy_d  = y1_q[0] * y1_q[0];
  assign r2sum  = sqx_q + sqy_q;
  assign r2sq_d = r2_q * r2_q;
  assign k1r2_d = k1 * $signed({1'b0, r2_q});
  assign k2r4_d = k2 * $signed({1'b0, r4_q});
  assign dsum_d = k2r4_q + k1r2c_q;
  assign sc_full = $signed(dsum_q[DsumW-1:QBits]) + ScW'(OneQ20);

  always_comb begin
    sc_d    = sc_full[ScQW-1:0];
    sc_clip = 1'b0;
    if (sc_full > ScW'(ScMax)) begin
      sc_d    = ScQW'(ScMax);
      sc_clip = 1'b1;
    end else if (sc_full < ScW'(ScMin)) begin
      sc_d    = ScQW'(ScMin);
      sc_clip = 1'b1;
    end
  end

  assign pxs_d = x1_q[7] * sc_q;
  assign pys_d = y1_q[7] * sc_q;
  assign x2_d  = dist_en_q ? $signed(pxs_q[PxsW-1:QBits]) : X2W'(x1_q[8]);
  assign y2_d  = dist_en_q ? $signed(pys_q[PxsW-1:QBits]) : X2W'(y1_q[8]);
  assign fxx_d = fx * x2_q;
  assign fyy_d = fy * y2_q;
  assign un_d  = $signed(fxx_q[FxxW-1:QBits]) + cx;
  assign vn_d  = $signed(fyy_q[FxxW-1:QBits]) + cy;
  assign uw_d  = un_q * $signed({1'b0, scr_w});
  assign vh_d  = vn_q * $signed({1'b0, scr_h});

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q[0]    <= x1_d;
      y1_q[0]    <= y1_d;
      flg_q[0].dz   <= sd.dz;
      flg_q[0].clip <= sd.sat_x | sd.sat_y;
      for (int i = 1; i < 9; i++) begin
        x1_q[i] <= x1_q[i-1];
        y1_q[i] <= y1_q[i-1];
      end
      for (int i = 1; i < PostStages; i++) begin
        if (i != 7) begin
          flg_q[i] <= flg_q[i-1];
        end
      end
      // Stage eight takes the scale limit, which only counts when distortion
      // is in use.
      flg_q[7].dz   <= flg_q[6].dz;
      flg_q[7].clip <= flg_q[6].clip | (dist_en_q & sc_clip);
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      r2_q    <= r2sum[QBits +: R2W];
      r2sq_q  <= r2sq_d;
      k1r2_q  <= k1r2_d;
      r4_q    <= r2sq_q[QBits +: R4W];
      k1r2b_q <= k1r2_q;
      k1r2c_q <= k1r2b_q;
      k2r4_q  <= k2r4_d;
      dsum_q  <= dsum_d;
      sc_q    <= sc_d;
      pxs_q   <= pxs_d;
      pys_q   <= pys_d;
      x2_q    <= x2_d;
      y2_q    <= y2_d;
      fxx_q   <= fxx_d;
      fyy_q   <= fyy_d;
      un_q    <= un_d;
      vn_q    <= vn_d;
      uw_q    <= uw_d;
      vh_q    <= vh_d;
    end
  end

  // Output stage: scale down to 1/16 pixel and limit to the port range.
  logic signed [PuW-1:0]       pu_full, pv_full;
  logic signed [CoordBits-1:0] pu_sat, pv_sat;
  logic                        clip_u, clip_v;
  flags_t                      fl;
  logic [CoordBits-1:0]        pu_q, pv_q;
  logic                        dz_q, clip_q;

  assign pu_full = $signed(uw_q[UwW-1:16]);
  assign pv_full = $signed(vh_q[UwW-1:16]);
  assign fl      = flg_q[PostStages-1];

  always_comb begin
    pu_sat = pu_full[CoordBits-1:0];
    clip_u = 1'b0;
    if (pu_full > PuW'(OutMax)) begin
      pu_sat = CoordBits'(OutMax);
      clip_u = 1'b1;
    end else if (pu_full < PuW'(OutMin)) begin
      pu_sat = CoordBits'(OutMin);
      clip_u = 1'b1;
    end
    pv_sat = pv_full[CoordBits-1:0];
    clip_v = 1'b0;
    if (pv_full > PuW'(OutMax)) begin
      pv_sat = CoordBits'(OutMax);
      clip_v = 1'b1;
    end else if (pv_full < PuW'(OutMin)) begin
      pv_sat = CoordBits'(OutMin);
      clip_v = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && pipe_v_q[PipeStages-1]) begin
      pu_q   <= fl.dz ? '0 : pu_sat;
      pv_q   <= fl.dz ? '0 : pv_sat;
      dz_q   <= fl.dz;
      clip_q <= !fl.dz && (fl.clip || clip_u || clip_v);
    end
  end

  assign m_axis_tdata = OutDataW'({pv_q, pu_q});
  assign m_axis_tuser = {clip_q, dz_q};

  `ASSERT_IMP(a_ready_low_only_when_full, clk_i, rst_ni, !s_axis_tready,
              out_v_q && !m_axis_tready && pipe_v_q[PipeStages-1], "stall without cause")
  `ASSERT_IMP(a_depth_zero_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0],
              m_axis_tdata == '0 && !m_axis_tuser[1], "zero depth word carries data")
  `ASSERT_NXT(a_accept_enters_pipe, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
              pipe_v_q[0], "accepted word missing from first stage")
  `ASSERT_NXT(a_last_stage_to_output, clk_i, rst_ni, en && pipe_v_q[PipeStages-1],
              out_v_q, "finished word not presented")

endmodule

`default_nettype wire

FILE: hdl/gpcp_div.sv
// Pipelined restoring divider: one quotient bit per stage, Q.20 result.
`default_nettype none

module gpcp_div (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [gpcp_pkg::MagW-1:0]  num_i,
  input  wire logic [gpcp_pkg::MagW-1:0]  den_i,
  output logic      [gpcp_pkg::QuoW-1:0]  quo_o
);
  import gpcp_pkg::*;

  // The partial remainder is kept below sixteen times the divisor and is
  // compared against eight times the divisor, so one quotient bit falls out
  // per stage with the binary point set twenty bits down.
  logic [RemW-1:0] rem_q [DivStages-1];
  logic [MagW-1:0] den_q [DivStages-1];
  logic [QuoW-1:0] quo_q [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [RemW-1:0] r_in;
    logic [RemW-1:0] dd;
    logic [RemW-1:0] diff;
    logic [MagW-1:0] d_in;
    logic [QuoW-1:0] q_in;
    logic            ge;

    if (k == 0) begin : g_first
      assign r_in = RemW'(num_i);
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
    end

    assign dd   = RemW'({d_in, 3'b000});
    assign ge   = (r_in >= dd);
    assign diff = r_in - dd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {q_in[QuoW-2:0], ge};
      end
    end

    if (k < DivStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? {diff[RemW-2:0], 1'b0} : {r_in[RemW-2:0], 1'b0};
          den_q[k] <= d_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

`default_nettype wire
